>>> rtl/tbo_pkg.sv
// shared types and constants of the triangle / box overlap pipeline
// no dependencies; used by every module under rtl
package tbo_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

	// reject stage codes
	localparam logic [1:0] STAGE_NONE   = 2'd0;
	localparam logic [1:0] STAGE_BOUNDS = 2'd1;
	localparam logic [1:0] STAGE_PLANE  = 2'd2;
	localparam logic [1:0] STAGE_EDGE   = 2'd3;

	// load enables of the pipeline registers
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} tbo_en_t;

endpackage

>>> rtl/tbo_setup.sv
// first stage: bounds test, centered vertices, half sizes and edge vectors
// depends on tbo_pkg
module tbo_setup #(
	parameter int W = 16
) (
	input  logic              clk,
	input  tbo_pkg::tbo_en_t  en,
	input  logic signed [W-1:0] t [3][3],
	input  logic signed [W-1:0] bmin [3],
	input  logic signed [W-1:0] bmax [3],
	output logic              bnd_rej_s1,
	output logic signed [W:0]   h_s1 [3],
	output logic signed [W+1:0] v_s1 [3][3],
	output logic signed [W:0]   e_s1 [3][3]
);
	import tbo_pkg::*;

	logic signed [W-1:0] lo [3];
	logic signed [W-1:0] hi [3];
	logic [2:0] rej;

	// triangle bounds against the box per axis
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lo[a] = t[0][a];
			hi[a] = t[0][a];
			for (int k = 1; k < 3; k++) begin
				if (t[k][a] < lo[a]) lo[a] = t[k][a];
				if (t[k][a] > hi[a]) hi[a] = t[k][a];
			end
			rej[a] = (lo[a] > bmax[a]) || (hi[a] < bmin[a]);
		end
	end

	// doubled coordinates centered on the box, edges
	always_ff @(posedge clk) begin
		if (en.s1) begin
			bnd_rej_s1 <= |rej;
			for (int a = 0; a < 3; a++) begin
				h_s1[a] <= (W+1)'(bmax[a]) - (W+1)'(bmin[a]);
				for (int k = 0; k < 3; k++)
					v_s1[k][a] <= ((W+2)'(t[k][a]) <<< 1) - (W+2)'(bmin[a])
						- (W+2)'(bmax[a]);
				e_s1[0][a] <= (W+1)'(t[1][a]) - (W+1)'(t[0][a]);
				e_s1[1][a] <= (W+1)'(t[2][a]) - (W+1)'(t[1][a]);
				e_s1[2][a] <= (W+1)'(t[0][a]) - (W+1)'(t[2][a]);
			end
		end
	end

endmodule

>>> rtl/tbo_plane.sv
// plane stage: triangle normal and box extent along it, stages two to four
// depends on tbo_pkg
module tbo_plane #(
	parameter int W = 16
) (
	input  logic              clk,
	input  tbo_pkg::tbo_en_t  en,
	input  logic signed [W:0]   e0 [3],
	input  logic signed [W:0]   e1 [3],
	input  logic signed [W:0]   h [3],
	input  logic signed [W+1:0] v0 [3],
	output logic              rej
);
	import tbo_pkg::*;

	localparam int MW = 2 * W + 2;
	localparam int NW = 2 * W + 3;
	localparam int CW = W + 3;
	localparam int PW = NW + CW;
	localparam int DW = PW + 2;

	logic signed [MW-1:0] m_s2 [6];
	logic signed [CW-1:0] up_s2 [3];
	logic signed [CW-1:0] dn_s2 [3];
	logic signed [NW-1:0] n_s3 [3];
	logic signed [CW-1:0] up_s3 [3];
	logic signed [CW-1:0] dn_s3 [3];
	logic signed [PW-1:0] pmin_s4 [3];
	logic signed [PW-1:0] pmax_s4 [3];
	logic signed [DW-1:0] dmin;
	logic signed [DW-1:0] dmax;

	// cross product terms and vertex distances to the box faces
	always_ff @(posedge clk) begin
		if (en.s2) begin
			m_s2[0] <= MW'(e0[1]) * MW'(e1[2]);
			m_s2[1] <= MW'(e0[2]) * MW'(e1[1]);
			m_s2[2] <= MW'(e0[2]) * MW'(e1[0]);
			m_s2[3] <= MW'(e0[0]) * MW'(e1[2]);
			m_s2[4] <= MW'(e0[0]) * MW'(e1[1]);
			m_s2[5] <= MW'(e0[1]) * MW'(e1[0]);
			for (int a = 0; a < 3; a++) begin
				up_s2[a] <= CW'(h[a]) - CW'(v0[a]);
				dn_s2[a] <= -CW'(h[a]) - CW'(v0[a]);
			end
		end
	end

	// normal
	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int a = 0; a < 3; a++) begin
				n_s3[a] <= NW'(m_s2[2*a]) - NW'(m_s2[2*a+1]);
				up_s3[a] <= up_s2[a];
				dn_s3[a] <= dn_s2[a];
			end
		end
	end

	// nearest and farthest box corner terms
	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int a = 0; a < 3; a++) begin
				if (n_s3[a] > 0) begin
					pmin_s4[a] <= PW'(n_s3[a]) * PW'(dn_s3[a]);
					pmax_s4[a] <= PW'(n_s3[a]) * PW'(up_s3[a]);
				end else begin
					pmin_s4[a] <= PW'(n_s3[a]) * PW'(up_s3[a]);
					pmax_s4[a] <= PW'(n_s3[a]) * PW'(dn_s3[a]);
				end
			end
		end
	end

	// box entirely on one side of the plane
	always_comb begin
		dmin = DW'(pmin_s4[0]) + DW'(pmin_s4[1]) + DW'(pmin_s4[2]);
		dmax = DW'(pmax_s4[0]) + DW'(pmax_s4[1]) + DW'(pmax_s4[2]);
		rej  = (dmin > 0) || (dmax < 0);
	end

endmodule

>>> rtl/tbo_axis.sv
// one edge cross axis test: projections, radius and compare over stages two to four
// depends on tbo_pkg
module tbo_axis #(
	parameter int W = 16
) (
	input  logic              clk,
	input  tbo_pkg::tbo_en_t  en,
	input  logic signed [W+1:0] ca,
	input  logic signed [W+1:0] cb,
	input  logic signed [W+1:0] va [3],
	input  logic signed [W+1:0] vb [3],
	input  logic signed [W:0]   ha,
	input  logic signed [W:0]   hb,
	output logic              sep_s4
);
	import tbo_pkg::*;

	localparam int PW = 2 * W + 4;
	localparam int SW = 2 * W + 6;

	logic signed [W+1:0] mag_a;
	logic signed [W+1:0] mag_b;
	logic signed [PW-1:0] pa_s2 [3];
	logic signed [PW-1:0] pb_s2 [3];
	logic signed [PW-1:0] ra_s2;
	logic signed [PW-1:0] rb_s2;
	logic signed [SW-1:0] p_s3 [3];
	logic signed [SW-1:0] rad_s3;
	logic signed [SW-1:0] pmin;
	logic signed [SW-1:0] pmax;

	assign mag_a = (ca < 0) ? -ca : ca;
	assign mag_b = (cb < 0) ? -cb : cb;

	// projection and radius products
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= PW'(ca) * PW'(va[k]);
				pb_s2[k] <= PW'(cb) * PW'(vb[k]);
			end
			ra_s2 <= PW'(mag_a) * PW'(ha);
			rb_s2 <= PW'(mag_b) * PW'(hb);
		end
	end

	// sums
	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int k = 0; k < 3; k++)
				p_s3[k] <= SW'(pa_s2[k]) + SW'(pb_s2[k]);
			rad_s3 <= SW'(ra_s2) + SW'(rb_s2);
		end
	end

	// projected interval against the box radius
	always_comb begin
		pmin = p_s3[0];
		pmax = p_s3[0];
		for (int k = 1; k < 3; k++) begin
			if (p_s3[k] < pmin) pmin = p_s3[k];
			if (p_s3[k] > pmax) pmax = p_s3[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4)
			sep_s4 <= (rad_s3 < pmin) || (pmax < -rad_s3);
	end

endmodule

>>> rtl/triangle_box_overlap_test.sv
// Triangle against axis-aligned box overlap test, five register stages deep.
// One triangle is taken every cycle while the output is not stalled, so the
// sustained rate is one item per cycle; each result passes through the setup,
// product, sum, corner product and result registers in a row. A stalled output
// holds the pipeline in place and bubbles close up. The user must write the box
// through the configuration port while no triangle is in flight; nothing enforces it.
// depends on tbo_pkg, tbo_setup, tbo_plane, tbo_axis
module triangle_box_overlap_test #(
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z, zero padding
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// overlap, reject_stage, zero padding
	output logic [7:0] m_tdata,
	input  logic cfg_we,
	input  logic [tbo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);
	import tbo_pkg::*;

	localparam int W = COORD_WIDTH;

	logic signed [W-1:0] box_min_q [3];
	logic signed [W-1:0] box_max_q [3];
	logic signed [W-1:0] t [3][3];

	logic v1_q, v2_q, v3_q, v4_q;
	logic adv1, adv2, adv3, adv4, adv5;
	tbo_en_t en;

	logic bnd_s1, bnd_s2, bnd_s3, bnd_s4;
	logic signed [W:0]   h_s1 [3];
	logic signed [W+1:0] v_s1 [3][3];
	logic signed [W:0]   e_s1 [3][3];
	logic signed [W+1:0] v0 [3];
	logic plane_rej;
	logic [8:0] sep;
	logic overlap_q;
	logic [1:0] stage_q;
	logic [1:0] stage_d;

	// box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_min_q[a] <= '0;
				box_max_q[a] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_MIN_X: box_min_q[0] <= cfg_data;
				REG_BOX_MIN_Y: box_min_q[1] <= cfg_data;
				REG_BOX_MIN_Z: box_min_q[2] <= cfg_data;
				REG_BOX_MAX_X: box_max_q[0] <= cfg_data;
				REG_BOX_MAX_Y: box_max_q[1] <= cfg_data;
				REG_BOX_MAX_Z: box_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// request unpacking
	always_comb begin
		for (int k = 0; k < 3; k++)
			for (int a = 0; a < 3; a++)
				t[k][a] = s_tdata[(3*k+a)*W +: W];
	end

	// stage handshake, a stage moves when it is empty or its successor moves
	assign adv5 = !m_tvalid || m_tready;
	assign adv4 = !v4_q || adv5;
	assign adv3 = !v3_q || adv4;
	assign adv2 = !v2_q || adv3;
	assign adv1 = !v1_q || adv2;
	assign s_tready = adv1;
	assign en = '{s1: adv1, s2: adv2, s3: adv3, s4: adv4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (adv1) v1_q <= s_tvalid;
			if (adv2) v2_q <= v1_q;
			if (adv3) v3_q <= v2_q;
			if (adv4) v4_q <= v3_q;
			if (adv5) m_tvalid <= v4_q;
		end
	end

	tbo_setup #(.W(W)) u_setup (
		.clk(clk), .en(en), .t(t), .bmin(box_min_q), .bmax(box_max_q),
		.bnd_rej_s1(bnd_s1), .h_s1(h_s1), .v_s1(v_s1), .e_s1(e_s1)
	);

	assign v0[0] = v_s1[0][0];
	assign v0[1] = v_s1[0][1];
	assign v0[2] = v_s1[0][2];

	tbo_plane #(.W(W)) u_plane (
		.clk(clk), .en(en), .e0(e_s1[0]), .e1(e_s1[1]), .h(h_s1), .v0(v0),
		.rej(plane_rej)
	);

	// edge cross axis tests, one for each pair of triangle edge and box axis
	for (genvar k = 0; k < 3; k++) begin : g_edge
		logic signed [W+1:0] ex, ey, ez;
		logic signed [W+1:0] vx [3];
		logic signed [W+1:0] vy [3];
		logic signed [W+1:0] vz [3];

		assign ex = (W+2)'(e_s1[k][0]);
		assign ey = (W+2)'(e_s1[k][1]);
		assign ez = (W+2)'(e_s1[k][2]);
		for (genvar j = 0; j < 3; j++) begin : g_vert
			assign vx[j] = v_s1[j][0];
			assign vy[j] = v_s1[j][1];
			assign vz[j] = v_s1[j][2];
		end

		tbo_axis #(.W(W)) u_ax (
			.clk(clk), .en(en), .ca(-ez), .cb(ey), .va(vy), .vb(vz),
			.ha(h_s1[1]), .hb(h_s1[2]), .sep_s4(sep[3*k])
		);
		tbo_axis #(.W(W)) u_ay (
			.clk(clk), .en(en), .ca(ez), .cb(-ex), .va(vx), .vb(vz),
			.ha(h_s1[0]), .hb(h_s1[2]), .sep_s4(sep[3*k+1])
		);
		tbo_axis #(.W(W)) u_az (
			.clk(clk), .en(en), .ca(-ey), .cb(ex), .va(vx), .vb(vy),
			.ha(h_s1[0]), .hb(h_s1[1]), .sep_s4(sep[3*k+2])
		);
	end

	// bounds verdict travels alongside
	always_ff @(posedge clk) begin
		if (adv2) bnd_s2 <= bnd_s1;
		if (adv3) bnd_s3 <= bnd_s2;
		if (adv4) bnd_s4 <= bnd_s3;
	end

	// first rejecting stage wins
	always_comb begin
		priority if (bnd_s4) stage_d = STAGE_BOUNDS;
		else if (plane_rej)  stage_d = STAGE_PLANE;
		else if (|sep)       stage_d = STAGE_EDGE;
		else                 stage_d = STAGE_NONE;
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			stage_q   <= stage_d;
			overlap_q <= (stage_d == STAGE_NONE);
		end
	end

	assign m_tdata = {5'b0, stage_q, overlap_q};

endmodule
